// ===== design/u2cal_pkg.sv =====
`default_nettype none

package u2cal_pkg;

  localparam int unsigned STAGES = 7;

  // 2000-01-01 00:00:00 UTC
  localparam logic [31:0] EPOCH_2000 = 32'd946684800;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [11:0] SECS_PER_MIN  = 12'd60;
  localparam logic [10:0] BLOCK_DAYS    = 11'd1461;
  localparam logic [10:0] COMMON_DAYS   = 11'd365;
  localparam logic [10:0] LEAP_DAYS     = 11'd366;
  localparam logic [11:0] BASE_YEAR     = 12'd1970;

  // years of a block run 365, 365, 366, 365 days
  localparam logic [10:0] Y1_START = COMMON_DAYS;
  localparam logic [10:0] Y2_START = 11'(2 * COMMON_DAYS);
  localparam logic [10:0] Y3_START = 11'(2 * COMMON_DAYS + LEAP_DAYS);

  // 1970-01-01 was a Thursday
  localparam logic [17:0] WEEK_OFFSET   = 18'd3;
  localparam logic [3:0]  DAYS_PER_WEEK = 4'd7;

  // Exact reciprocal multipliers: ceil(2^k / d) with k = input bits + ceil(log2 d).
  // days = (ts >> 7) / 675, 25-bit dividend
  localparam int unsigned DAY_SHIFT = 35;
  localparam logic [25:0] DAY_MULT =
    26'(((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675);
  // block = days / 1461, 16-bit dividend
  localparam int unsigned BLOCK_SHIFT = 27;
  localparam logic [16:0] BLOCK_MULT =
    17'(((64'd1 << BLOCK_SHIFT) + 64'd1460) / 64'd1461);
  // hour = (secs >> 4) / 225, 13-bit dividend
  localparam int unsigned HOUR_SHIFT = 21;
  localparam logic [13:0] HOUR_MULT =
    14'(((64'd1 << HOUR_SHIFT) + 64'd224) / 64'd225);
  // minute = (rem >> 2) / 15, 10-bit dividend
  localparam int unsigned MIN_SHIFT = 14;
  localparam logic [10:0] MIN_MULT =
    11'(((64'd1 << MIN_SHIFT) + 64'd14) / 64'd15);

  // Day of year at which each month starts, common year
  localparam logic [8:0] MONTH_START [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

`default_nettype wire

// ===== design/unix_time_to_calendar_top.sv =====
// An accepted item passes through stage registers 1 to 7 in order; out_valid is the stage 7 valid bit.
// Throughput: one item per cycle while out_ready is high; a 7-register pipeline
// that does its divisions as constant multiplies (reciprocal division).
// Each stage advances whenever the stage after it is empty or moving on.
// Reset (rst_n, synchronous, active low) clears the stage valid bits only.
`default_nettype none

module unix_time_to_calendar_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_unix_seconds,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_status,
  output logic [11:0]      out_year,
  output logic [3:0]       out_month,
  output logic [4:0]       out_day_of_month,
  output logic [4:0]       out_hour,
  output logic [5:0]       out_minute,
  output logic [5:0]       out_second,
  output logic [2:0]       out_weekday
);

  // ---------------- pipeline control ----------------
  logic [u2cal_pkg::STAGES:1]   vld_r;
  logic [u2cal_pkg::STAGES+1:1] en;
  logic [u2cal_pkg::STAGES:2]   err_r;

  always_comb begin
    en[u2cal_pkg::STAGES+1] = out_ready;
    for (int k = u2cal_pkg::STAGES; k >= 1; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1];
  assign out_valid = vld_r[u2cal_pkg::STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= u2cal_pkg::STAGES; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // ---------------- stage 1: input register ----------------
  logic [31:0] s1_ts_r;

  always_ff @(posedge clk) begin
    if (en[1]) s1_ts_r <= in_unix_seconds;
  end

  // ---------------- stage 2: day count ----------------
  logic [50:0] day_prod;
  logic [15:0] s2_days_r;
  logic [16:0] s2_tslo_r;

  assign day_prod = 51'(s1_ts_r[31:7]) * 51'(u2cal_pkg::DAY_MULT);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_days_r <= day_prod[u2cal_pkg::DAY_SHIFT +: 16];
      s2_tslo_r <= s1_ts_r[16:0];
      err_r[2]  <= (s1_ts_r < u2cal_pkg::EPOCH_2000);
    end
  end

  // ---------------- stage 3: seconds of day, block, weekday ----------------
  logic [16:0] day_secs;
  logic [32:0] blk_prod;
  logic [17:0] wk_t;
  logic [5:0]  wk_sum;
  logic [3:0]  wk_fold;
  logic [3:0]  wk_mod;
  logic [15:0] s3_days_r;
  logic [16:0] s3_secs_r;
  logic [5:0]  s3_block_r;
  logic [2:0]  s3_wday_r;

  assign day_secs = s2_tslo_r - 17'(s2_days_r * u2cal_pkg::SECS_PER_DAY);
  assign blk_prod = 33'(s2_days_r) * 33'(u2cal_pkg::BLOCK_MULT);

  // mod 7 by summing octal digits, since 8 = 1 mod 7
  always_comb begin
    wk_t   = 18'(s2_days_r) + u2cal_pkg::WEEK_OFFSET;
    wk_sum = '0;
    for (int g = 0; g < 6; g++) begin
      wk_sum = wk_sum + 6'(wk_t[3*g +: 3]);
    end
    wk_fold = 4'(wk_sum[5:3]) + 4'(wk_sum[2:0]);
    wk_mod  = (wk_fold >= u2cal_pkg::DAYS_PER_WEEK) ?
              wk_fold - u2cal_pkg::DAYS_PER_WEEK : wk_fold;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_days_r  <= s2_days_r;
      s3_secs_r  <= day_secs;
      s3_block_r <= blk_prod[u2cal_pkg::BLOCK_SHIFT +: 6];
      s3_wday_r  <= wk_mod[2:0] + 3'd1;
      err_r[3]   <= err_r[2];
    end
  end

  // ---------------- stage 4: day in block, hour ----------------
  logic [15:0] blk_days;
  logic [15:0] blk_rem;
  logic [26:0] hour_prod;
  logic [10:0] s4_doyb_r;
  logic [11:0] s4_year_r;
  logic [16:0] s4_secs_r;
  logic [4:0]  s4_hour_r;
  logic [2:0]  s4_wday_r;

  assign blk_days  = 16'(s3_block_r) * 16'(u2cal_pkg::BLOCK_DAYS);
  assign blk_rem   = s3_days_r - blk_days;
  assign hour_prod = 27'(s3_secs_r[16:4]) * 27'(u2cal_pkg::HOUR_MULT);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_doyb_r <= blk_rem[10:0];
      s4_year_r <= u2cal_pkg::BASE_YEAR + {4'd0, s3_block_r, 2'b00};
      s4_secs_r <= s3_secs_r;
      s4_hour_r <= hour_prod[u2cal_pkg::HOUR_SHIFT +: 5];
      s4_wday_r <= s3_wday_r;
      err_r[4]  <= err_r[3];
    end
  end

  // ---------------- stage 5: year in block, seconds of hour ----------------
  logic [1:0]  yr_idx;
  logic [10:0] yr_off;
  logic [10:0] doy_full;
  logic [11:0] year_full;
  logic [16:0] hour_secs;
  logic [16:0] hr_rem;
  logic [8:0]  s5_doy_r;
  logic [11:0] s5_year_r;
  logic        s5_leap_r;
  logic [11:0] s5_remh_r;
  logic [4:0]  s5_hour_r;
  logic [2:0]  s5_wday_r;

  always_comb begin
    if (s4_doyb_r >= u2cal_pkg::Y3_START) begin
      yr_idx = 2'd3;
      yr_off = u2cal_pkg::Y3_START;
    end else if (s4_doyb_r >= u2cal_pkg::Y2_START) begin
      yr_idx = 2'd2;
      yr_off = u2cal_pkg::Y2_START;
    end else if (s4_doyb_r >= u2cal_pkg::Y1_START) begin
      yr_idx = 2'd1;
      yr_off = u2cal_pkg::Y1_START;
    end else begin
      yr_idx = 2'd0;
      yr_off = '0;
    end
    doy_full  = s4_doyb_r - yr_off;
    year_full = s4_year_r + 12'(yr_idx);
  end

  assign hour_secs = 17'(s4_hour_r) * 17'(u2cal_pkg::SECS_PER_HOUR);
  assign hr_rem    = s4_secs_r - hour_secs;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_doy_r  <= doy_full[8:0];
      s5_year_r <= year_full;
      s5_leap_r <= (year_full[1:0] == 2'b00);
      s5_remh_r <= hr_rem[11:0];
      s5_hour_r <= s4_hour_r;
      s5_wday_r <= s4_wday_r;
      err_r[5]  <= err_r[4];
    end
  end

  // ---------------- stage 6: month, day, minute ----------------
  logic [3:0]  mon_idx;
  logic [8:0]  mon_base;
  logic [8:0]  day_ofs;
  logic [20:0] min_prod;
  logic [3:0]  s6_month_r;
  logic [4:0]  s6_day_r;
  logic [5:0]  s6_minute_r;
  logic [11:0] s6_remh_r;
  logic [11:0] s6_year_r;
  logic [4:0]  s6_hour_r;
  logic [2:0]  s6_wday_r;

  // month starts are increasing, so the last one reached wins
  always_comb begin
    mon_idx = '0;
    for (int m = 1; m < 12; m++) begin
      if (s5_doy_r >= u2cal_pkg::MONTH_START[4'(m)] + 9'((m >= 2) && s5_leap_r)) begin
        mon_idx = 4'(m);
      end
    end
    mon_base = u2cal_pkg::MONTH_START[mon_idx] + 9'((mon_idx >= 4'd2) && s5_leap_r);
    day_ofs  = s5_doy_r - mon_base;
  end

  assign min_prod = 21'(s5_remh_r[11:2]) * 21'(u2cal_pkg::MIN_MULT);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_month_r  <= mon_idx + 4'd1;
      s6_day_r    <= day_ofs[4:0] + 5'd1;
      s6_minute_r <= min_prod[u2cal_pkg::MIN_SHIFT +: 6];
      s6_remh_r   <= s5_remh_r;
      s6_year_r   <= s5_year_r;
      s6_hour_r   <= s5_hour_r;
      s6_wday_r   <= s5_wday_r;
      err_r[6]    <= err_r[5];
    end
  end

  // ---------------- stage 7: second, result register ----------------
  logic [11:0] min_secs;
  logic [11:0] sec_rem;
  logic [11:0] year_r;
  logic [3:0]  month_r;
  logic [4:0]  day_r;
  logic [4:0]  hour_r;
  logic [5:0]  minute_r;
  logic [5:0]  second_r;
  logic [2:0]  wday_r;

  assign min_secs = 12'(s6_minute_r) * u2cal_pkg::SECS_PER_MIN;
  assign sec_rem  = s6_remh_r - min_secs;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      err_r[7] <= err_r[6];
      if (err_r[6]) begin
        year_r   <= '0;
        month_r  <= '0;
        day_r    <= '0;
        hour_r   <= '0;
        minute_r <= '0;
        second_r <= '0;
        wday_r   <= '0;
      end else begin
        year_r   <= s6_year_r;
        month_r  <= s6_month_r;
        day_r    <= s6_day_r;
        hour_r   <= s6_hour_r;
        minute_r <= s6_minute_r;
        second_r <= sec_rem[5:0];
        wday_r   <= s6_wday_r;
      end
    end
  end

  assign out_status       = err_r[7];
  assign out_year         = year_r;
  assign out_month        = month_r;
  assign out_day_of_month = day_r;
  assign out_hour         = hour_r;
  assign out_minute       = minute_r;
  assign out_second       = second_r;
  assign out_weekday      = wday_r;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_year == 12'd0 && out_month == 4'd0 &&
      out_day_of_month == 5'd0 && out_hour == 5'd0 && out_minute == 6'd0 &&
      out_second == 6'd0 && out_weekday == 3'd0)
    else $error("range error result carries nonzero fields");

  a_ok_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_status |-> out_month >= 4'd1 && out_month <= 4'd12 &&
      out_day_of_month >= 5'd1 && out_hour <= 5'd23 && out_minute <= 6'd59 &&
      out_second <= 6'd59 && out_weekday >= 3'd1 && out_weekday <= 3'd7)
    else $error("calendar field out of range");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[1])
    else $error("accepted item did not enter the pipeline");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;

  localparam logic STATUS_OK          = 1'b0;
  localparam logic STATUS_BEFORE_2000 = 1'b1;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_ITEMS = 1190;

  localparam logic [31:0] FIRST_2000_SEC = 32'd946684800;
  localparam int unsigned SEC_PER_DAY    = 86400;
  localparam int unsigned DAYS_IN_BLOCK  = 1461;

  // cumulative day count at each month start, common year
  localparam int unsigned MONTH_FIRST_DAY [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  typedef struct packed {
    logic        status;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  mday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } calendar_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_unix_seconds = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_status;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_second;
  logic [2:0]  out_weekday;

  calendar_t   pending_dates [$];
  calendar_t   got_date;
  calendar_t   want_date;

  int unsigned cycle_count = 0;
  int unsigned fail_count = 0;
  int unsigned results_checked = 0;
  int unsigned stamps_sent = 0;
  int unsigned stamps_early = 0;
  int unsigned stamps_past_2099 = 0;
  int unsigned stall_left = 0;
  int unsigned hold_request = 0;
  int unsigned hold_left = 0;
  bit          sender_calm = 1'b0;
  bit          receiver_calm = 1'b0;

  unix_time_to_calendar_top DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_unix_seconds  (in_unix_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second),
    .out_weekday      (out_weekday)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_dates.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Calendar date from a Unix timestamp. Years run in 4-year blocks from 1970,
  // the third year of each block being the leap one, so 2100 counts as leap.
  function automatic calendar_t calendar_of(input logic [31:0] ts);
    calendar_t   r;
    int unsigned days, secs, doy, yr, mon, first;
    int          m;
    bit          leap;
    r = '0;
    if (ts < FIRST_2000_SEC) begin
      r.status = STATUS_BEFORE_2000;
      return r;
    end
    days = ts / SEC_PER_DAY;
    secs = ts % SEC_PER_DAY;
    yr   = 1970 + (days / DAYS_IN_BLOCK) * 4;
    doy  = days % DAYS_IN_BLOCK;
    if (doy >= 365) begin doy -= 365; yr++; end
    if (doy >= 365) begin doy -= 365; yr++; end
    if (doy >= 366) begin doy -= 366; yr++; end
    leap = (yr % 4) == 0;
    mon  = 1;
    for (m = 11; m >= 1 && mon == 1; m--) begin
      first = MONTH_FIRST_DAY[m] + ((m >= 2 && leap) ? 1 : 0);
      if (doy >= first) begin
        mon = m + 1;
        doy -= first;
      end
    end
    r.status  = STATUS_OK;
    r.year    = 12'(yr);
    r.month   = 4'(mon);
    r.mday    = 5'(doy + 1);
    r.hour    = 5'(secs / 3600);
    r.minute  = 6'((secs % 3600) / 60);
    r.second  = 6'(secs % 60);
    r.weekday = 3'(((days + 3) % 7) + 1);
    return r;
  endfunction

  function automatic string date_text(input calendar_t c);
    return $sformatf("st=%0d %0d-%0d-%0d %0d:%0d:%0d wd=%0d", c.status, c.year,
                     c.month, c.mday, c.hour, c.minute, c.second, c.weekday);
  endfunction

  // receiver: per-item stall from the monitor, long hold counted here
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_checked++;
      got_date = {out_status, out_year, out_month, out_day_of_month,
                  out_hour, out_minute, out_second, out_weekday};
      if (pending_dates.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected result: %s", date_text(got_date));
      end else begin
        want_date = pending_dates.pop_front();
        if (got_date !== want_date) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("mismatch: expected %s, got %s",
                     date_text(want_date), date_text(got_date));
        end
      end
      stall_left = receiver_calm ? 0 : $urandom_range(0, 3);
    end
  end

  // Leaves in_valid high after acceptance; the next send with a gap, or a drain, lowers it.
  task automatic send_stamp(input logic [31:0] ts);
    int unsigned gap, i;
    calendar_t   exp_date;
    gap = sender_calm ? 0 : $urandom_range(0, 3);
    for (i = 0; i < gap; i++) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid        <= 1'b1;
    in_unix_seconds <= ts;
    do @(posedge clk); while (!in_ready);
    exp_date = calendar_of(ts);
    pending_dates.push_back(exp_date);
    stamps_sent++;
    if (exp_date.status == STATUS_BEFORE_2000) stamps_early++;
    else if (exp_date.year >= 12'd2100) stamps_past_2099++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
  endtask

  task automatic test_boundary_stamps();
    logic [31:0] stamps [$];
    stamps = '{32'd0, 32'hFFFFFFFF, 32'd946684799, 32'd946684800,
               32'd951782399, 32'd951782400, 32'd951868800, 32'd978307199,
               32'd978307200, 32'd1009843200, 32'd1072915200, 32'd1234567890,
               32'h7FFFFFFF, 32'h80000000, 32'h55555555, 32'hAAAAAAAA,
               32'd4102444799, 32'd4102444800, 32'd4107542400,
               32'd4107628800, 32'd4107715199};
    foreach (stamps[k]) send_stamp(stamps[k]);
    wait_drained();
  endtask

  // Month boundary, either the first day or the last day of the month before.
  function automatic logic [31:0] month_edge_stamp();
    int unsigned blk, yidx, m, d, s;
    int unsigned year_off [4];
    logic [63:0] wide;
    year_off = '{0, 365, 730, 1096};
    blk  = $urandom_range(33, 7);
    yidx = $urandom_range(0, 3);
    m    = $urandom_range(0, 11);
    d    = blk * DAYS_IN_BLOCK + year_off[yidx] + MONTH_FIRST_DAY[m]
           + ((yidx == 2 && m >= 2) ? 1 : 0);
    if ($urandom_range(0, 1)) d = d - 1;
    s    = $urandom_range(0, 1) ? 86399 : $urandom_range(86399, 0);
    wide = 64'(d) * 64'(SEC_PER_DAY) + 64'(s);
    return wide[31:0];
  endfunction

  task automatic test_random_stamps();
    int unsigned i, d;
    logic [31:0] ts;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 150 == 0) begin
        sender_calm   = ($urandom_range(0, 2) == 0);
        receiver_calm = sender_calm;
      end
      case ($urandom_range(0, 9))
        0: ts = $urandom;
        1: ts = $urandom_range(32'd946684799, 0);
        2: begin
          d  = $urandom_range(49709, 10957);
          ts = 32'(d * SEC_PER_DAY) + ($urandom_range(0, 1) ? 32'd86399 : 32'd0);
        end
        3: ts = month_edge_stamp();
        default: ts = $urandom_range(32'hFFFFFFFF, FIRST_2000_SEC);
      endcase
      send_stamp(ts);
    end
    sender_calm   = 1'b0;
    receiver_calm = 1'b0;
    wait_drained();
  endtask

  // Receiver blocks long enough for the pipeline to fill and push back.
  task automatic test_backpressure();
    int unsigned i;
    hold_request = 80;
    sender_calm  = 1'b1;
    for (i = 0; i < 30; i++) send_stamp($urandom_range(32'hFFFFFFFF, 0));
    sender_calm  = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_boundary_stamps();
    test_backpressure();
    test_random_stamps();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d timestamps sent (%0d before 2000, %0d from 2100 on), %0d results checked",
             stamps_sent, stamps_early, stamps_past_2099, results_checked);
    $display("%0d failures over %0d cycles", fail_count, cycle_count);
    if (fail_count == 0 && pending_dates.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
